@@ hw/rtl/rbd_pkg.sv @@
// shared constants, word types and bin helpers for the rms bin downscaler
`default_nettype none

package rbd_pkg;

    localparam int OUT_DIM = 256;
    localparam int MAX_DIM = 4096;
    localparam int DIM_W = 13;
    localparam int POS_W = $clog2(MAX_DIM);
    localparam int OIDX_W = $clog2(OUT_DIM) + 1;
    localparam int ADDR_W = $clog2(OUT_DIM);
    localparam int CNT_W = 5;
    localparam int SUM_W = 20;
    localparam int ROOT_W = SUM_W / 2;
    localparam int CFG_IDX_W = 2;
    localparam int LANES = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       end_of_row;
        logic       end_of_frame;
    } pix_out_t;

    // request to the rms unit
    typedef struct packed {
        logic                             start;
        logic [CNT_W-1:0]                 divisor;
        logic [LANES-1:0][SUM_W-1:0]      sum;
    } rms_req_t;

    // status and results from the rms unit
    typedef struct packed {
        logic                             busy;
        logic                             done;
        logic [LANES-1:0][7:0]            root;
    } rms_rsp_t;

    // register value clamped to the supported range
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (r == '0)
            r = DIM_W'(1);
        if (r > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    // end of bin idx along a dimension, rounded to nearest
    function automatic logic [DIM_W-1:0] bin_limit(input logic [OIDX_W-1:0] idx,
                                                   input logic [DIM_W-1:0] dim);
        logic [OIDX_W:0]            n;
        logic [OIDX_W+DIM_W+1:0]    p;
        n = {1'b0, idx} + (OIDX_W+1)'(1);
        p = (OIDX_W+DIM_W+2)'(n) * (OIDX_W+DIM_W+2)'(dim)
            + (OIDX_W+DIM_W+2)'(OUT_DIM / 2);
        return DIM_W'(p >> $clog2(OUT_DIM));
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rbd_rms_unit.sv @@
// iterative floor(sqrt(floor(sum / count))) for three channels
`default_nettype none

module rbd_rms_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  rbd_pkg::rms_req_t    req,
    output rbd_pkg::rms_rsp_t    rsp
);

    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_ROOT
    } rstate_t;

    localparam int STEP_W = $clog2(rbd_pkg::SUM_W);

    rstate_t                                    state_reg;
    logic [STEP_W-1:0]                          step_reg;
    logic [rbd_pkg::CNT_W-1:0]                  div_reg;
    logic [rbd_pkg::LANES-1:0][rbd_pkg::SUM_W-1:0]   num_reg;
    logic [rbd_pkg::LANES-1:0][rbd_pkg::CNT_W-1:0]   drem_reg;
    logic [rbd_pkg::LANES-1:0][rbd_pkg::ROOT_W:0]    srem_reg;
    logic [rbd_pkg::LANES-1:0][rbd_pkg::ROOT_W-1:0]  root_reg;
    logic                                       done_reg;

    logic [rbd_pkg::LANES-1:0][rbd_pkg::SUM_W-1:0]   num_next;
    logic [rbd_pkg::LANES-1:0][rbd_pkg::CNT_W-1:0]   drem_next;
    logic [rbd_pkg::LANES-1:0][rbd_pkg::ROOT_W:0]    srem_next;
    logic [rbd_pkg::LANES-1:0][rbd_pkg::ROOT_W-1:0]  root_next;

    // one quotient bit or one root bit per lane each cycle
    always_comb
    begin
        logic [rbd_pkg::CNT_W-1:0]  dsh;
        logic [rbd_pkg::ROOT_W+1:0] rsh;
        logic [rbd_pkg::ROOT_W+1:0] trial;
        for (int c = 0; c < rbd_pkg::LANES; c++)
        begin
            dsh = {drem_reg[c][rbd_pkg::CNT_W-2:0], num_reg[c][rbd_pkg::SUM_W-1]};
            rsh = {srem_reg[c][rbd_pkg::ROOT_W-1:0],
                   num_reg[c][rbd_pkg::SUM_W-1:rbd_pkg::SUM_W-2]};
            trial = {root_reg[c], 2'b01};
            num_next[c] = num_reg[c];
            drem_next[c] = drem_reg[c];
            srem_next[c] = srem_reg[c];
            root_next[c] = root_reg[c];
            if (state_reg == R_DIV)
            begin
                if (dsh >= div_reg)
                begin
                    drem_next[c] = dsh - div_reg;
                    num_next[c] = {num_reg[c][rbd_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next[c] = dsh;
                    num_next[c] = {num_reg[c][rbd_pkg::SUM_W-2:0], 1'b0};
                end
            end
            else if (state_reg == R_ROOT)
            begin
                num_next[c] = {num_reg[c][rbd_pkg::SUM_W-3:0], 2'b00};
                if (rsh >= trial)
                begin
                    srem_next[c] = (rbd_pkg::ROOT_W+1)'(rsh - trial);
                    root_next[c] = {root_reg[c][rbd_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next[c] = (rbd_pkg::ROOT_W+1)'(rsh);
                    root_next[c] = {root_reg[c][rbd_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // sequencer: divide phase then root phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            step_reg <= '0;
            div_reg <= '0;
            num_reg <= '0;
            drem_reg <= '0;
            srem_reg <= '0;
            root_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            num_reg <= num_next;
            drem_reg <= drem_next;
            srem_reg <= srem_next;
            root_reg <= root_next;
            case (state_reg)
                R_IDLE:
                begin
                    if (req.start)
                    begin
                        num_reg <= req.sum;
                        div_reg <= req.divisor;
                        drem_reg <= '0;
                        step_reg <= '0;
                        state_reg <= R_DIV;
                    end
                end
                R_DIV:
                begin
                    if (step_reg == STEP_W'(rbd_pkg::SUM_W - 1))
                    begin
                        step_reg <= '0;
                        srem_reg <= '0;
                        root_reg <= '0;
                        state_reg <= R_ROOT;
                    end
                    else
                        step_reg <= step_reg + STEP_W'(1);
                end
                R_ROOT:
                begin
                    if (step_reg == STEP_W'(rbd_pkg::ROOT_W - 1))
                    begin
                        done_reg <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                    else
                        step_reg <= step_reg + STEP_W'(1);
                end
                default:
                    state_reg <= R_IDLE;
            endcase
        end
    end

    always_comb
    begin
        rsp.busy = (state_reg != R_IDLE);
        rsp.done = done_reg;
        for (int c = 0; c < rbd_pkg::LANES; c++)
            rsp.root[c] = root_reg[c][7:0];
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == R_IDLE)
        else $error("rms unit started while busy");
    a_done_from_root: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == R_ROOT)
        else $error("rms done outside root phase");
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> req.divisor != '0)
        else $error("rms started with zero count");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rms_bin_downscaler_256.sv @@
// top level: rms bin downscaler with per-column sum memory
//
// in_data carries one source pixel per word in raster order (valid/stall);
// out_data carries one output pixel per word with end of row and frame marks.
// cfg_we/cfg_index/cfg_data write source_width (index 0) or source_height
// (index 1); a write restarts the frame. The user must make a write only
// while idle; the block itself does not enforce this. A dimension of 256
// or less passes through; a larger one is binned to 256. A pass-through
// pixel, and with width binned a pixel that ends no horizontal bin, leaves
// the block idle for the next pixel. A pixel ending a horizontal bin runs
// the rms unit once (20 divide steps, 10 root steps, then done); when
// height is binned it then does the column memory read-modify-write and,
// on the last row of a vertical bin, one more rms pass; with only height
// binned every pixel takes that path. The input stalls until it is idle.
// One output word is held in a register; while that word is held by
// out_stall the input stalls, and a ready result waits for the register.
// Reset sets width and height to 256 and starts a fresh frame; the
// column memory needs no clearing since each entry is written before read.
`default_nettype none

module rms_bin_downscaler_256 (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  rbd_pkg::pix_in_t                        in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output rbd_pkg::pix_out_t                       out_data,
    input  wire logic                               cfg_we,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rbd_pkg::DIM_W-1:0]          cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HRMS,
        S_RD,
        S_ACC,
        S_VRMS,
        S_EMIT
    } state_t;

    localparam int L = rbd_pkg::LANES;
    localparam int SW = rbd_pkg::SUM_W;

    state_t                                 state_reg;
    logic [rbd_pkg::DIM_W-1:0]              width_reg;
    logic [rbd_pkg::DIM_W-1:0]              height_reg;
    logic [rbd_pkg::POS_W-1:0]              src_col_reg;
    logic [rbd_pkg::POS_W-1:0]              src_row_reg;
    logic [rbd_pkg::OIDX_W-1:0]             out_col_reg;
    logic [rbd_pkg::OIDX_W-1:0]             out_row_reg;
    logic [rbd_pkg::DIM_W-1:0]              col_end_reg;
    logic [rbd_pkg::DIM_W-1:0]              row_end_reg;
    logic [rbd_pkg::CNT_W-1:0]              col_cnt_reg;
    logic [rbd_pkg::CNT_W-1:0]              row_cnt_reg;
    logic [L-1:0][SW-1:0]                   row_sum_reg;
    logic [L-1:0][7:0]                      hv_reg;
    logic [rbd_pkg::ADDR_W-1:0]             idx_reg;
    logic                                   first_reg;
    logic                                   vend_reg;
    logic [rbd_pkg::CNT_W-1:0]              vdiv_reg;
    logic                                   eor_reg;
    logic                                   eof_reg;
    logic [L-1:0][7:0]                      res_reg;
    logic                                   out_valid_reg;
    rbd_pkg::pix_out_t                      out_data_reg;

    logic [L-1:0][SW-1:0]                   col_mem [rbd_pkg::OUT_DIM];
    logic [L-1:0][SW-1:0]                   rdata_reg;

    logic [rbd_pkg::DIM_W-1:0]  w_eff;
    logic [rbd_pkg::DIM_W-1:0]  h_eff;
    logic                       w_scale;
    logic                       h_scale;
    logic [rbd_pkg::DIM_W-1:0]  col_pos1;
    logic [rbd_pkg::DIM_W-1:0]  row_pos1;
    logic                       row_last;
    logic                       row_final;
    logic                       row_hit;
    logic                       frame_last;
    logic                       hend;
    logic                       out_free;
    logic                       accept;
    logic                       cfg_hit;
    logic [rbd_pkg::DIM_W-1:0]  new_w;
    logic [rbd_pkg::DIM_W-1:0]  new_h;
    logic [L-1:0][7:0]          px;
    logic [L-1:0][SW-1:0]       sum_acc;
    logic [L-1:0][SW-1:0]       acc_word;
    rbd_pkg::rms_req_t          rms_req;
    rbd_pkg::rms_rsp_t          rms_rsp;

    // effective sizes and position flags
    assign w_eff = rbd_pkg::eff_dim(width_reg);
    assign h_eff = rbd_pkg::eff_dim(height_reg);
    assign w_scale = w_eff > rbd_pkg::DIM_W'(rbd_pkg::OUT_DIM);
    assign h_scale = h_eff > rbd_pkg::DIM_W'(rbd_pkg::OUT_DIM);
    assign col_pos1 = rbd_pkg::DIM_W'(src_col_reg) + rbd_pkg::DIM_W'(1);
    assign row_pos1 = rbd_pkg::DIM_W'(src_row_reg) + rbd_pkg::DIM_W'(1);
    assign row_last = col_pos1 >= w_eff;
    assign row_final = row_pos1 >= h_eff;
    assign row_hit = row_pos1 >= row_end_reg;
    assign frame_last = row_last && row_final;
    assign hend = w_scale && ((col_pos1 >= col_end_reg) || row_last);

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    // configuration decode
    assign cfg_hit = cfg_we && ((cfg_index == rbd_pkg::REG_SOURCE_WIDTH) ||
                                (cfg_index == rbd_pkg::REG_SOURCE_HEIGHT));
    assign new_w = (cfg_index == rbd_pkg::REG_SOURCE_WIDTH) ?
                   rbd_pkg::eff_dim(cfg_data) : w_eff;
    assign new_h = (cfg_index == rbd_pkg::REG_SOURCE_HEIGHT) ?
                   rbd_pkg::eff_dim(cfg_data) : h_eff;

    // squares of the incoming pixel and of the horizontal result
    assign px[0] = in_data.red;
    assign px[1] = in_data.green;
    assign px[2] = in_data.blue;
    always_comb
    begin
        for (int c = 0; c < L; c++)
        begin
            sum_acc[c] = row_sum_reg[c] + SW'(px[c] * px[c]);
            acc_word[c] = first_reg ? SW'(hv_reg[c] * hv_reg[c]) :
                          rdata_reg[c] + SW'(hv_reg[c] * hv_reg[c]);
        end
    end

    // requests to the shared rms unit
    always_comb
    begin
        rms_req.start = (accept && hend) || ((state_reg == S_ACC) && vend_reg);
        rms_req.divisor = (state_reg == S_ACC) ? vdiv_reg :
                          col_cnt_reg + rbd_pkg::CNT_W'(1);
        rms_req.sum = (state_reg == S_ACC) ? acc_word : sum_acc;
    end

    rbd_rms_unit u_rms (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (rms_req),
        .rsp  (rms_rsp)
    );

    // column sum memory, one read-modify-write per horizontal result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACC)
            col_mem[idx_reg] <= acc_word;
        rdata_reg <= col_mem[idx_reg];
    end

    // frame position, bin tracking and result sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            width_reg <= rbd_pkg::DIM_W'(rbd_pkg::OUT_DIM);
            height_reg <= rbd_pkg::DIM_W'(rbd_pkg::OUT_DIM);
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_end_reg <= rbd_pkg::bin_limit('0, rbd_pkg::DIM_W'(rbd_pkg::OUT_DIM));
            row_end_reg <= rbd_pkg::bin_limit('0, rbd_pkg::DIM_W'(rbd_pkg::OUT_DIM));
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            row_sum_reg <= '0;
            hv_reg <= '0;
            idx_reg <= '0;
            first_reg <= 1'b0;
            vend_reg <= 1'b0;
            vdiv_reg <= '0;
            eor_reg <= 1'b0;
            eof_reg <= 1'b0;
            res_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // configuration write restarts the frame
            if (cfg_hit)
            begin
                if (cfg_index == rbd_pkg::REG_SOURCE_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
                src_col_reg <= '0;
                src_row_reg <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                col_cnt_reg <= '0;
                row_cnt_reg <= '0;
                row_sum_reg <= '0;
                col_end_reg <= rbd_pkg::bin_limit('0, new_w);
                row_end_reg <= rbd_pkg::bin_limit('0, new_h);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // latch per-word context for the later stages
                        idx_reg <= w_scale ? out_col_reg[rbd_pkg::ADDR_W-1:0] :
                                             src_col_reg[rbd_pkg::ADDR_W-1:0];
                        first_reg <= (row_cnt_reg == '0);
                        vend_reg <= row_hit || row_final;
                        vdiv_reg <= row_cnt_reg + rbd_pkg::CNT_W'(1);
                        eor_reg <= row_last;
                        eof_reg <= frame_last;
                        hv_reg <= px;

                        // horizontal bin accumulation
                        src_col_reg <= src_col_reg + rbd_pkg::POS_W'(1);
                        if (w_scale)
                        begin
                            if (hend)
                            begin
                                col_cnt_reg <= '0;
                                row_sum_reg <= '0;
                                out_col_reg <= out_col_reg + rbd_pkg::OIDX_W'(1);
                                col_end_reg <= rbd_pkg::bin_limit(
                                    out_col_reg + rbd_pkg::OIDX_W'(1), w_eff);
                            end
                            else
                            begin
                                col_cnt_reg <= col_cnt_reg + rbd_pkg::CNT_W'(1);
                                row_sum_reg <= sum_acc;
                            end
                        end

                        // row wrap and vertical bin tracking
                        if (row_last)
                        begin
                            src_col_reg <= '0;
                            out_col_reg <= '0;
                            col_cnt_reg <= '0;
                            row_sum_reg <= '0;
                            col_end_reg <= rbd_pkg::bin_limit('0, w_eff);
                            if (h_scale)
                            begin
                                if (row_hit)
                                begin
                                    row_cnt_reg <= '0;
                                    out_row_reg <= out_row_reg + rbd_pkg::OIDX_W'(1);
                                    row_end_reg <= rbd_pkg::bin_limit(
                                        out_row_reg + rbd_pkg::OIDX_W'(1), h_eff);
                                end
                                else
                                    row_cnt_reg <= row_cnt_reg + rbd_pkg::CNT_W'(1);
                            end
                            src_row_reg <= src_row_reg + rbd_pkg::POS_W'(1);
                            if (frame_last)
                            begin
                                src_row_reg <= '0;
                                out_row_reg <= '0;
                                row_cnt_reg <= '0;
                                row_end_reg <= rbd_pkg::bin_limit('0, h_eff);
                            end
                        end

                        // route the word
                        if (w_scale)
                        begin
                            if (hend)
                                state_reg <= S_HRMS;
                        end
                        else if (h_scale)
                            state_reg <= S_RD;
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            out_data_reg <= '{out_red: px[0], out_green: px[1],
                                              out_blue: px[2], end_of_row: row_last,
                                              end_of_frame: frame_last};
                        end
                    end
                end
                S_HRMS:
                begin
                    if (rms_rsp.done)
                    begin
                        hv_reg <= rms_rsp.root;
                        res_reg <= rms_rsp.root;
                        state_reg <= h_scale ? S_RD : S_EMIT;
                    end
                end
                S_RD:
                    state_reg <= S_ACC;
                S_ACC:
                    state_reg <= vend_reg ? S_VRMS : S_IDLE;
                S_VRMS:
                begin
                    if (rms_rsp.done)
                    begin
                        res_reg <= rms_rsp.root;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= '{out_red: res_reg[0], out_green: res_reg[1],
                                          out_blue: res_reg[2], end_of_row: eor_reg,
                                          end_of_frame: eof_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_rms_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        rms_req.start |-> !rms_rsp.busy)
        else $error("rms request while unit busy");
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        rms_rsp.done |-> (state_reg == S_HRMS || state_reg == S_VRMS))
        else $error("rms result with no waiting word");
    a_no_row_count: assert property (@(posedge clk) disable iff (!rst_n)
        !h_scale |-> row_cnt_reg == '0)
        else $error("row bin count moved without vertical binning");
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> out_valid_reg)
        else $error("result word lost at emit");
`endif

endmodule

`default_nettype wire

@@ test/tb_rms_bin_downscaler_256.sv @@
// testbench for the rms bin downscaler: directed table, random frames, scoreboard
`default_nettype none

module tb_rms_bin_downscaler_256;

    localparam logic [rbd_pkg::CFG_IDX_W-1:0] REG_UNUSED = rbd_pkg::CFG_IDX_W'(3);
    localparam int SETTLE_CYCLES = 200;

    typedef enum int {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_mode_t;

    typedef struct {
        logic [rbd_pkg::DIM_W-1:0] width_reg;
        logic [rbd_pkg::DIM_W-1:0] height_reg;
        rbd_pkg::pix_in_t          pixel;
        bit                        typed;
        rbd_pkg::pix_out_t         want;
    } table_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    rbd_pkg::pix_in_t              in_data = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    rbd_pkg::pix_out_t             out_data;
    logic                          cfg_we = 1'b0;
    logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rbd_pkg::DIM_W-1:0]     cfg_data = '0;

    idle_mode_t idle_mode = IDLE_SENDER_LIGHT;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;
    int         hold_left = 0;
    int         errors = 0;

    // predictor state
    logic [rbd_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [63:0] row_acc [3];
    logic [63:0] col_acc [rbd_pkg::OUT_DIM][3];
    int unsigned src_col, src_row, bin_col, bin_row, col_cnt, row_cnt;
    longint unsigned col_end, row_end;
    rbd_pkg::pix_out_t expected_pixels[$];

    rms_bin_downscaler_256 u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // size register clamped to 1..MAX_DIM
    function automatic int unsigned clamp_dim(logic [rbd_pkg::DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > rbd_pkg::MAX_DIM)
            return rbd_pkg::MAX_DIM;
        return v;
    endfunction

    // first source index past bin i, rounded to nearest
    function automatic longint unsigned bin_stop(int unsigned i, int unsigned d);
        return ((longint'(i) + 1) * d + rbd_pkg::OUT_DIM / 2) / rbd_pkg::OUT_DIM;
    endfunction

    function automatic logic [7:0] floor_root(longint unsigned x);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= x)
                r = r + (64'd1 << b);
        return r[7:0];
    endfunction

    function automatic void restart_frame();
        for (int c = 0; c < 3; c++)
            row_acc[c] = 0;
        src_col = 0; src_row = 0; bin_col = 0; bin_row = 0;
        col_cnt = 0; row_cnt = 0;
        col_end = bin_stop(0, clamp_dim(width_reg));
        row_end = bin_stop(0, clamp_dim(height_reg));
    endfunction

    // one source pixel through the binning, queues the output pixel if one ends
    function automatic void predict_pixel(rbd_pkg::pix_in_t p);
        int unsigned w, h, oc, idx;
        logic [7:0] px [3];
        logic [7:0] hv [3];
        logic [7:0] res [3];
        bit have, emit, row_last, frame_last;
        rbd_pkg::pix_out_t o;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        px[0] = p.red; px[1] = p.green; px[2] = p.blue;
        row_last = (src_col + 1 >= w);
        frame_last = row_last && (src_row + 1 >= h);
        have = 0; emit = 0; oc = 0;
        if (w > rbd_pkg::OUT_DIM) begin
            for (int c = 0; c < 3; c++)
                row_acc[c] += px[c] * px[c];
            col_cnt++;
            if (src_col + 1 >= col_end || row_last) begin
                for (int c = 0; c < 3; c++) begin
                    hv[c] = floor_root(row_acc[c] / col_cnt);
                    row_acc[c] = 0;
                end
                oc = bin_col; have = 1; col_cnt = 0; bin_col++;
                col_end = bin_stop(bin_col, w);
            end
        end else begin
            hv = px; oc = src_col; have = 1;
        end
        if (have) begin
            if (h > rbd_pkg::OUT_DIM) begin
                idx = (oc < rbd_pkg::OUT_DIM) ? oc : rbd_pkg::OUT_DIM - 1;
                for (int c = 0; c < 3; c++)
                    if (row_cnt == 0)
                        col_acc[idx][c] = hv[c] * hv[c];
                    else
                        col_acc[idx][c] += hv[c] * hv[c];
                if (src_row + 1 >= row_end || src_row + 1 >= h) begin
                    for (int c = 0; c < 3; c++)
                        res[c] = floor_root(col_acc[idx][c] / (row_cnt + 1));
                    emit = 1;
                end
            end else begin
                res = hv; emit = 1;
            end
            if (emit) begin
                o = '{res[0], res[1], res[2], row_last, frame_last};
                expected_pixels.push_back(o);
            end
        end
        src_col++;
        if (row_last) begin
            src_col = 0; bin_col = 0; col_cnt = 0;
            for (int c = 0; c < 3; c++)
                row_acc[c] = 0;
            col_end = bin_stop(0, w);
            if (h > rbd_pkg::OUT_DIM) begin
                if (src_row + 1 >= row_end) begin
                    row_cnt = 0; bin_row++;
                    row_end = bin_stop(bin_row, h);
                end else begin
                    row_cnt++;
                end
            end
            src_row++;
            if (frame_last)
                restart_frame();
        end
    endfunction

    // offer one word, hold it until taken
    task automatic send_pixel(rbd_pkg::pix_in_t p);
        in_data <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // idle cycles before the next word, each taken with the mode's chance
    task automatic sender_gap();
        int pct;
        pct = (idle_mode == IDLE_SENDER_LIGHT) ? 12 : (idle_mode == IDLE_SENDER_HEAVY) ? 71 : 0;
        while ($urandom_range(99) < pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [rbd_pkg::CFG_IDX_W-1:0] idx,
                             logic [rbd_pkg::DIM_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == rbd_pkg::REG_SOURCE_WIDTH) begin
            width_reg = val;
            restart_frame();
        end else if (idx == rbd_pkg::REG_SOURCE_HEIGHT) begin
            height_reg = val;
            restart_frame();
        end
    endtask

    function automatic rbd_pkg::pix_in_t random_pixel();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        return rbd_pkg::pix_in_t'(24'($urandom));
    endfunction

    // receiver: random stall plus one long hold-off
    always @(posedge clk) begin
        int pct;
        pct = (idle_mode == IDLE_SENDER_LIGHT) ? 71 : (idle_mode == IDLE_SENDER_HEAVY) ? 12 : 0;
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < pct);
        end
    end

    // output checker
    always @(posedge clk) begin
        rbd_pkg::pix_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected word %p", $time, out_data);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (out_data !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial begin
        table_row_t rows [20];
        int unsigned phase_w [10];
        int unsigned phase_h [10];
        int unsigned phase_n [10];
        rows = '{
            '{256, 256, '{8'h00, 8'h00, 8'h00}, 1, '{8'h00, 8'h00, 8'h00, 0, 0}},
            '{256, 256, '{8'hff, 8'hff, 8'hff}, 1, '{8'hff, 8'hff, 8'hff, 0, 0}},
            '{256, 256, '{8'hff, 8'h00, 8'h00}, 1, '{8'hff, 8'h00, 8'h00, 0, 0}},
            '{256, 256, '{8'h00, 8'hff, 8'h00}, 1, '{8'h00, 8'hff, 8'h00, 0, 0}},
            '{256, 256, '{8'h00, 8'h00, 8'hff}, 1, '{8'h00, 8'h00, 8'hff, 0, 0}},
            '{256, 256, '{8'h55, 8'haa, 8'h55}, 1, '{8'h55, 8'haa, 8'h55, 0, 0}},
            '{256, 256, '{8'haa, 8'h55, 8'haa}, 1, '{8'haa, 8'h55, 8'haa, 0, 0}},
            '{256, 256, '{8'h01, 8'h80, 8'hfe}, 1, '{8'h01, 8'h80, 8'hfe, 0, 0}},
            // zero sizes act as one: with both zero every pixel is a whole frame
            '{0, 0, '{8'hff, 8'h00, 8'hff}, 1, '{8'hff, 8'h00, 8'hff, 1, 1}},
            '{0, 0, '{8'h00, 8'hff, 8'h00}, 1, '{8'h00, 8'hff, 8'h00, 1, 1}},
            '{0, 0, '{8'h12, 8'h34, 8'h56}, 1, '{8'h12, 8'h34, 8'h56, 1, 1}},
            '{2, 0, '{8'h7f, 8'h80, 8'h81}, 1, '{8'h7f, 8'h80, 8'h81, 0, 0}},
            '{2, 0, '{8'hfe, 8'h01, 8'h00}, 1, '{8'hfe, 8'h01, 8'h00, 1, 1}},
            // horizontal binning, bins of one and two pixels
            '{300, 1, '{8'hff, 8'hff, 8'h00}, 0, '0},
            '{300, 1, '{8'h00, 8'hff, 8'hff}, 0, '0},
            '{300, 1, '{8'hff, 8'h00, 8'h01}, 0, '0},
            '{300, 1, '{8'h03, 8'hc0, 8'h40}, 0, '0},
            // vertical binning
            '{1, 300, '{8'hff, 8'h80, 8'h00}, 0, '0},
            '{1, 300, '{8'h00, 8'h80, 8'hff}, 0, '0},
            '{1, 300, '{8'h11, 8'hee, 8'h77}, 0, '0}
        };
        phase_w = '{3, 300, 1, 300, 8191, 1, 257, 2, 256, 40};
        phase_h = '{2, 5, 300, 300, 1, 8191, 3, 257, 256, 9};
        phase_n = '{60, 400, 200, 400, 200, 100, 260, 80, 90, 160};

        width_reg = 256;
        height_reg = 256;
        restart_frame();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[i]) begin
            if (rows[i].width_reg != width_reg || rows[i].height_reg != height_reg) begin
                drain();
                write_reg(rbd_pkg::REG_SOURCE_WIDTH, rows[i].width_reg);
                write_reg(rbd_pkg::REG_SOURCE_HEIGHT, rows[i].height_reg);
            end
            send_pixel(rows[i].pixel);
            if (rows[i].typed) begin
                predict_pixel(rows[i].pixel);
                void'(expected_pixels.pop_back());
                expected_pixels.push_back(rows[i].want);
            end else begin
                predict_pixel(rows[i].pixel);
            end
        end

        // random frames
        foreach (phase_w[ph]) begin
            drain();
            idle_mode = (ph < 3) ? IDLE_SENDER_LIGHT : (ph < 6) ? IDLE_SENDER_HEAVY : IDLE_NONE;
            if (ph == 6)
                write_reg(REG_UNUSED, '1);
            write_reg(rbd_pkg::REG_SOURCE_WIDTH, phase_w[ph]);
            write_reg(rbd_pkg::REG_SOURCE_HEIGHT, phase_h[ph]);
            for (int n = 0; n < phase_n[ph]; n++) begin
                rbd_pkg::pix_in_t p;
                p = random_pixel();
                if (ph == 1 && n == 100)
                    hold_req = 1'b1;
                sender_gap();
                send_pixel(p);
                predict_pixel(p);
            end
        end
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
